FILE: src/assert_macros.svh
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every clock edge outside reset.
`define CFMR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define CFMR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CFMR_ASSERT(lbl, clk, rst, prop, msg)
`define CFMR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/crc_fmr_pkg.sv
`default_nettype none

package crc_fmr_pkg;

   // Frame format
   localparam logic [15:0] FRAME_MAGIC = 16'h1337;
   localparam logic [15:0] CRC_SEED    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   localparam int          DEFAULT_MAX_FRAME_PAYLOAD = 4096;
   localparam logic [12:0] MAX_PAYLOAD_RESET         = 13'd4096;

   // Result kinds
   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_STATUS  = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERR   = 2'd3;

   // Reply codes on the wire
   localparam logic [2:0] REPLY_OK      = 3'd0;
   localparam logic [2:0] REPLY_CRC_ERR = 3'd4;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  frame_status;
      logic [12:0] frame_length;
      logic        send_reply;
      logic [2:0]  reply_code;
   } result_type;

   // CRC-16, reflected 0x8005, one byte LSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: src/crc_fmr_in_reg.sv
`default_nettype none

module crc_fmr_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       advance,
   output logic            item_valid,
   output logic [7:0]      item_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       take;

   // Take a new transaction when the register is empty or moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the byte until the parser consumes it
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

`default_nettype wire

FILE: src/crc_fmr_parser.sv
`default_nettype none
`include "assert_macros.svh"

module crc_fmr_parser #(
   parameter int MAX_FRAME_PAYLOAD = crc_fmr_pkg::DEFAULT_MAX_FRAME_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        item_valid,
   input  wire logic [7:0]  item_byte,
   input  wire logic        advance,
   input  wire logic [12:0] max_payload,
   output logic             has_result,
   output crc_fmr_pkg::result_type result
);

   import crc_fmr_pkg::*;

   localparam logic [15:0] FRAME_CAP = 16'(MAX_FRAME_PAYLOAD);

   typedef enum logic [6:0] {
      PH_MAGIC_LO = 7'b0000001,
      PH_MAGIC_HI = 7'b0000010,
      PH_LEN_LO   = 7'b0000100,
      PH_LEN_HI   = 7'b0001000,
      PH_PAYLOAD  = 7'b0010000,
      PH_CRC_LO   = 7'b0100000,
      PH_CRC_HI   = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [12:0] count_ff, count_in;
   logic [12:0] length_ff, length_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held_ff, held_in;
   logic        magic_ok_ff, magic_ok_in;

   logic [15:0] crc_next;
   logic [15:0] word;
   logic [15:0] limit;
   logic [12:0] count_inc;

   assign crc_next  = crc16_byte(crc_ff, item_byte);
   assign word      = {item_byte, held_ff};
   assign limit     = ({3'b000, max_payload} > FRAME_CAP) ? FRAME_CAP : {3'b000, max_payload};
   assign count_inc = count_ff + 13'd1;

   // Decode the byte against the current frame phase
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      length_in   = length_ff;
      crc_in      = crc_ff;
      held_in     = held_ff;
      magic_ok_in = magic_ok_ff;
      has_result  = 1'b0;
      result      = '0;
      case (phase_ff)
         PH_MAGIC_HI: begin
            crc_in      = crc_next;
            magic_ok_in = (word == FRAME_MAGIC);
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            crc_in   = crc_next;
            held_in  = item_byte;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            crc_in = crc_next;
            if (!magic_ok_ff || (word > limit)) begin
               // Reject the header and drop back to hunting
               has_result          = 1'b1;
               result.result_kind  = RESULT_STATUS;
               result.frame_status = magic_ok_ff ? STATUS_TOO_LONG : STATUS_BAD_MAGIC;
               phase_in            = PH_MAGIC_LO;
               count_in            = '0;
               length_in           = '0;
               crc_in              = CRC_SEED;
               held_in             = '0;
               magic_ok_in         = 1'b0;
            end else begin
               length_in = word[12:0];
               count_in  = '0;
               phase_in  = (word == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_in              = crc_next;
            count_in            = count_inc;
            has_result          = 1'b1;
            result.result_kind  = RESULT_PAYLOAD;
            result.payload_byte = item_byte;
            if (count_inc >= length_ff) begin
               phase_in = PH_CRC_LO;
            end
         end
         PH_CRC_LO: begin
            held_in  = item_byte;
            phase_in = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            has_result          = 1'b1;
            result.result_kind  = RESULT_STATUS;
            result.frame_length = length_ff;
            result.send_reply   = 1'b1;
            if ((crc_ff ^ CRC_SEED) == word) begin
               result.frame_status = STATUS_OK;
               result.reply_code   = REPLY_OK;
            end else begin
               result.frame_status = STATUS_CRC_ERR;
               result.reply_code   = REPLY_CRC_ERR;
            end
            phase_in    = PH_MAGIC_LO;
            count_in    = '0;
            length_in   = '0;
            crc_in      = CRC_SEED;
            held_in     = '0;
            magic_ok_in = 1'b0;
         end
         default: begin
            // First header byte; unknown codes restart here too
            phase_in    = PH_MAGIC_HI;
            count_in    = '0;
            length_in   = '0;
            crc_in      = crc16_byte(CRC_SEED, item_byte);
            held_in     = item_byte;
            magic_ok_in = 1'b0;
         end
      endcase
   end

   // Advance the frame state once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC_LO;
         count_ff    <= '0;
         length_ff   <= '0;
         crc_ff      <= CRC_SEED;
         held_ff     <= '0;
         magic_ok_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         length_ff   <= length_in;
         crc_ff      <= crc_in;
         held_ff     <= held_in;
         magic_ok_ff <= magic_ok_in;
      end
   end

   `CFMR_ASSERT(a_advance_needs_item, clock, reset, advance |-> item_valid, "parser advanced without a byte")
   `CFMR_ASSERT(a_count_in_frame, clock, reset, count_ff <= length_ff, "payload count ran past frame length")
   `CFMR_ASSERT(a_footer_ends_frame, clock, reset, (advance && phase_ff == PH_CRC_HI) |=> (phase_ff == PH_MAGIC_LO && crc_ff == CRC_SEED), "frame did not restart after footer")
   `CFMR_ASSERT(a_payload_gives_byte, clock, reset, (phase_ff == PH_PAYLOAD) |-> (has_result && result.result_kind == RESULT_PAYLOAD), "payload byte without a result")

endmodule

`default_nettype wire

FILE: src/crc_fmr_out_reg.sv
`default_nettype none

module crc_fmr_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire crc_fmr_pkg::result_type load_data,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output crc_fmr_pkg::result_type rsp_data
);

   import crc_fmr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Fill on load, drain when the consumer takes the transaction
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

FILE: src/crc_framed_message_receiver_unit.sv
// Frame receiver for a byte link: takes one received byte per transaction on the req_ channel,
// parses a 4-byte little-endian header (magic 0x1337, then a 16-bit payload length), the payload
// and a 2-byte little-endian CRC-16 footer (reflected 0x8005, seed 0xFFFF, final XOR 0xFFFF,
// covering header and payload). Each payload byte comes out on the rsp_ channel as a payload
// result; at the end of a frame, or on a bad magic or a length over min(max_payload,
// MAX_FRAME_PAYLOAD), one status result follows and the receiver hunts for a new header at the
// very next byte. Header and footer bytes other than the last give no result. One byte is taken
// every cycle while results drain; a byte passes the input register, then the CRC byte update
// and frame state logic into the result register. max_payload resets to 4096 and is written
// through the csr_ port; the user must do so only while idle, which the block does not enforce.
`default_nettype none
`include "assert_macros.svh"

module crc_framed_message_receiver_unit #(
   parameter int MAX_FRAME_PAYLOAD = crc_fmr_pkg::DEFAULT_MAX_FRAME_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [12:0] csr_max_payload,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [1:0]       rsp_frame_status,
   output logic [12:0]      rsp_frame_length,
   output logic             rsp_send_reply,
   output logic [2:0]       rsp_reply_code
);

   import crc_fmr_pkg::*;

   logic [12:0] max_payload_ff;
   logic        item_valid;
   logic [7:0]  item_byte;
   logic        has_result;
   logic        advance;
   logic        load;
   result_type  result;
   result_type  rsp_data;

   // Hold the payload limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_valid) begin
         max_payload_ff <= csr_max_payload;
      end
   end

   // Move the held byte on unless its result would overwrite an untaken one
   assign advance = item_valid && (!has_result || !rsp_valid || rsp_ready);
   assign load    = advance && has_result;

   crc_fmr_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item_valid  (item_valid),
      .item_byte   (item_byte)
   );

   crc_fmr_parser #(
      .MAX_FRAME_PAYLOAD (MAX_FRAME_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_byte   (item_byte),
      .advance     (advance),
      .max_payload (max_payload_ff),
      .has_result  (has_result),
      .result      (result)
   );

   crc_fmr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_data (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_kind  = rsp_data.result_kind;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_status = rsp_data.frame_status;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_send_reply   = rsp_data.send_reply;
   assign rsp_reply_code   = rsp_data.reply_code;

   `CFMR_ASSERT(a_no_overwrite, clock, reset, load |-> (!rsp_valid || rsp_ready), "result register overwritten before it was taken")
   `CFMR_ASSERT(a_stall_blocks_input, clock, reset, (item_valid && has_result && rsp_valid && !rsp_ready) |-> !req_ready, "input taken while the parser is stalled")

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Frame parser tracker: mirrors the receiver's header/payload/footer parsing,
// queues the results each received byte should cause and checks the DUT output.
class deframe_tracker;
   typedef enum logic [2:0] {
      MAGIC_LO, MAGIC_HI, LENGTH_LO, LENGTH_HI, PAYLOAD, FOOTER_LO, FOOTER_HI
   } parse_phase_type;

   parse_phase_type phase;
   logic [12:0]  max_payload;
   logic [12:0]  byte_count;
   logic [12:0]  frame_len;
   logic [15:0]  crc;
   logic [7:0]   low_byte;
   logic         magic_good;

   crc_fmr_pkg::result_type pending_results[$];
   int mismatches;
   int bytes_in;
   int payload_seen;
   int status_seen[4];

   function new();
      max_payload  = crc_fmr_pkg::MAX_PAYLOAD_RESET;
      mismatches   = 0;
      bytes_in     = 0;
      payload_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      restart();
   endfunction

   // Drop the current frame and hunt for a new header
   function void restart();
      phase      = MAGIC_LO;
      byte_count = '0;
      frame_len  = '0;
      crc        = crc_fmr_pkg::CRC_SEED;
      low_byte   = '0;
      magic_good = 1'b0;
   endfunction

   // Reflected CRC-16, one byte shifted in LSB first
   static function logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      logic lsb;
      c = c ^ {8'h00, b};
      repeat (8) begin
         lsb = c[0];
         c   = c >> 1;
         if (lsb) c = c ^ crc_fmr_pkg::CRC_POLY;
      end
      return c;
   endfunction

   function int unsigned effective_limit();
      if (max_payload > crc_fmr_pkg::DEFAULT_MAX_FRAME_PAYLOAD)
         return crc_fmr_pkg::DEFAULT_MAX_FRAME_PAYLOAD;
      return 32'(max_payload);
   endfunction

   function void set_max_payload(logic [12:0] value);
      max_payload = value;
   endfunction

   function bit hunting();
      return phase == MAGIC_LO;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   function void push_status(logic [1:0] status, logic [12:0] len, logic reply,
                             logic [2:0] code);
      crc_fmr_pkg::result_type r;
      r              = '0;
      r.result_kind  = crc_fmr_pkg::RESULT_STATUS;
      r.frame_status = status;
      r.frame_length = len;
      r.send_reply   = reply;
      r.reply_code   = code;
      pending_results.push_back(r);
   endfunction

   // Advance the parser by one accepted byte
   function void take_byte(logic [7:0] b);
      crc_fmr_pkg::result_type r;
      logic [15:0] len16;
      bytes_in++;
      case (phase)
         MAGIC_HI: begin
            crc        = crc16_update(crc, b);
            magic_good = ({b, low_byte} == crc_fmr_pkg::FRAME_MAGIC);
            phase      = LENGTH_LO;
         end
         LENGTH_LO: begin
            crc      = crc16_update(crc, b);
            low_byte = b;
            phase    = LENGTH_HI;
         end
         LENGTH_HI: begin
            crc   = crc16_update(crc, b);
            len16 = {b, low_byte};
            // magic is judged before the length
            if (!magic_good) begin
               push_status(crc_fmr_pkg::STATUS_BAD_MAGIC, '0, 1'b0, '0);
               restart();
            end else if (len16 > effective_limit()) begin
               push_status(crc_fmr_pkg::STATUS_TOO_LONG, '0, 1'b0, '0);
               restart();
            end else begin
               frame_len  = len16[12:0];
               byte_count = '0;
               phase      = (frame_len == 0) ? FOOTER_LO : PAYLOAD;
            end
         end
         PAYLOAD: begin
            crc        = crc16_update(crc, b);
            byte_count = byte_count + 1'b1;
            if (byte_count >= frame_len) phase = FOOTER_LO;
            r              = '0;
            r.result_kind  = crc_fmr_pkg::RESULT_PAYLOAD;
            r.payload_byte = b;
            pending_results.push_back(r);
         end
         FOOTER_LO: begin
            low_byte = b;
            phase    = FOOTER_HI;
         end
         FOOTER_HI: begin
            if ((crc ^ crc_fmr_pkg::CRC_SEED) == {b, low_byte})
               push_status(crc_fmr_pkg::STATUS_OK, frame_len, 1'b1, crc_fmr_pkg::REPLY_OK);
            else
               push_status(crc_fmr_pkg::STATUS_CRC_ERR, frame_len, 1'b1,
                           crc_fmr_pkg::REPLY_CRC_ERR);
            restart();
         end
         default: begin
            restart();
            crc      = crc16_update(crc_fmr_pkg::CRC_SEED, b);
            low_byte = b;
            phase    = MAGIC_HI;
         end
      endcase
   endfunction

   // Compare one accepted result with the oldest queued one
   function void check_result(crc_fmr_pkg::result_type got);
      crc_fmr_pkg::result_type want;
      if (pending_results.size() == 0) begin
         if (mismatches < 10)
            $display("[%0t] unexpected result: kind=%0d byte=%02h status=%0d len=%0d %s",
                     $realtime, got.result_kind, got.payload_byte, got.frame_status,
                     got.frame_length,
                     $sformatf("reply=%0d code=%0d", got.send_reply, got.reply_code));
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      if (want.result_kind == crc_fmr_pkg::RESULT_PAYLOAD) payload_seen++;
      else status_seen[want.frame_status]++;
      if (got.result_kind  !== want.result_kind  || got.payload_byte !== want.payload_byte ||
          got.frame_status !== want.frame_status || got.frame_length !== want.frame_length ||
          got.send_reply   !== want.send_reply   || got.reply_code   !== want.reply_code) begin
         if (mismatches < 10) begin
            $display("[%0t] mismatch: want kind=%0d byte=%02h status=%0d len=%0d %s",
                     $realtime, want.result_kind, want.payload_byte, want.frame_status,
                     want.frame_length,
                     $sformatf("reply=%0d code=%0d", want.send_reply, want.reply_code));
            $display("            got  kind=%0d byte=%02h status=%0d len=%0d %s",
                     got.result_kind, got.payload_byte, got.frame_status,
                     got.frame_length,
                     $sformatf("reply=%0d code=%0d", got.send_reply, got.reply_code));
         end
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import crc_fmr_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [12:0] csr_max_payload;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_frame_status;
   logic [12:0] rsp_frame_length;
   logic        rsp_send_reply;
   logic [2:0]  rsp_reply_code;

   deframe_tracker tracker;
   logic [7:0]     frame_bytes[$];
   int             burst_left;
   int             settings_used;
   int             ready_pct;
   int             ready_window = 0;

   crc_framed_message_receiver_unit #(
      .MAX_FRAME_PAYLOAD(DEFAULT_MAX_FRAME_PAYLOAD)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_payload  (csr_max_payload),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_send_reply   (rsp_send_reply),
      .rsp_reply_code   (rsp_reply_code)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result side in windows of varying pressure
   always @(negedge clock) begin
      if (ready_window == 0) begin
         ready_window = $urandom_range(16, 300);
         case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 80;
            2:       ready_pct = 50;
            default: ready_pct = 15;
         endcase
      end
      ready_window--;
      rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
   end

   // Check every result transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result({rsp_result_kind, rsp_payload_byte, rsp_frame_status,
                               rsp_frame_length, rsp_send_reply, rsp_reply_code});
   end

   // Send one byte in bursts with random gaps; called and returns at a falling edge
   task send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b);
      burst_left--;
      @(negedge clock);
   endtask

   function void add_header(input logic [15:0] magic, input logic [15:0] len);
      frame_bytes.push_back(magic[7:0]);
      frame_bytes.push_back(magic[15:8]);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(len[15:8]);
   endfunction

   function void add_payload(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Append the footer over everything queued so far, optionally corrupted
   function void add_footer(input logic [15:0] flip);
      logic [15:0] c;
      c = CRC_SEED;
      foreach (frame_bytes[i]) c = crc16_byte(c, frame_bytes[i]);
      c = c ^ CRC_SEED ^ flip;
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   // Send the queued frame, then random bytes until the parser hunts again
   task send_frame_bytes();
      while (frame_bytes.size() > 0) send_byte(frame_bytes.pop_front());
      while (!tracker.hunting()) send_byte(8'($urandom_range(0, 255)));
   endtask

   function logic [15:0] pick_length(input int unsigned lim);
      if (lim <= 64 && $urandom_range(0, 7) == 0) return 16'(lim);
      return 16'($urandom_range(0, (lim < 12) ? lim : 12));
   endfunction

   // Mostly well-formed frames, the rest corrupted, rejected, cut short or noise
   task random_frame();
      int unsigned lim;
      logic [15:0] len;
      int          pick;
      lim  = tracker.effective_limit();
      len  = pick_length(lim);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         add_header(FRAME_MAGIC, len);
         add_payload(len);
         add_footer('0);
      end else if (pick < 70) begin
         add_header(FRAME_MAGIC, len);
         add_payload(len);
         add_footer(16'h1 << $urandom_range(0, 15));
      end else if (pick < 80) begin
         add_header(FRAME_MAGIC ^ (16'h1 << $urandom_range(0, 15)),
                    16'($urandom_range(0, 65535)));
      end else if (pick < 90) begin
         add_header(FRAME_MAGIC,
                    16'($urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535)));
      end else if (pick < 95) begin
         add_header(FRAME_MAGIC, len);
         add_payload((len == 0) ? 0 : $urandom_range(0, len - 1));
      end else begin
         add_payload($urandom_range(1, 6));
      end
      send_frame_bytes();
   endtask

   // Write the limit once all results are out and the pipeline has drained
   task write_max_payload(input logic [12:0] value);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_max_payload <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_max_payload(value);
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int cfg_values[7] = '{0, 1, 5, 8191, 4096, 37, -1};
      int phase_end;
      tracker         = new();
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_max_payload = '0;
      req_valid       = 1'b0;
      req_rx_byte     = '0;
      burst_left      = 0;
      settings_used   = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-length frame goes straight to the footer
      add_header(FRAME_MAGIC, 16'h0000);
      add_footer('0);
      send_frame_bytes();
      // bad magic and bad length together report bad magic
      add_header(16'h00FF, 16'hFFFF);
      send_frame_bytes();
      // length compared at full 16 bits, and one past the cap
      add_header(FRAME_MAGIC, 16'hFFFF);
      send_frame_bytes();
      add_header(FRAME_MAGIC, 16'd4097);
      send_frame_bytes();
      // corrupted footer
      add_header(FRAME_MAGIC, 16'd2);
      add_payload(2);
      add_footer(16'h8000);
      send_frame_bytes();

      phase_end = tracker.bytes_in + 125;
      while (tracker.bytes_in < phase_end) random_frame();

      foreach (cfg_values[i]) begin
         write_max_payload(13'((cfg_values[i] < 0) ? $urandom_range(0, 8191) : cfg_values[i]));
         // a limit above the cap still rejects one byte past the cap
         if (cfg_values[i] == 8191) begin
            add_header(FRAME_MAGIC, 16'd4097);
            send_frame_bytes();
         end
         phase_end = tracker.bytes_in + 125;
         while (tracker.bytes_in < phase_end) random_frame();
      end

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Run covered %0d bytes under %0d limit settings: %0d payload bytes delivered,",
               tracker.bytes_in, settings_used, tracker.payload_seen);
      $display("  frame reports ok=%0d bad_magic=%0d too_long=%0d crc_error=%0d, %0d mismatches",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_BAD_MAGIC],
               tracker.status_seen[STATUS_TOO_LONG], tracker.status_seen[STATUS_CRC_ERR],
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Hard stop if the handshakes hang
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
